### sv/itoa_pkg.sv
// Package for the integer to ASCII converter: mode codes, FSM states,
// digit-path control struct and character constants. No dependencies.
package itoa_pkg;

  localparam int VALUE_BITS = 64;
  localparam int ACTION_BITS = 3;

  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_OCT  = 3'd2,
    ACT_HEXL = 3'd3,
    ACT_HEXU = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   load;
    logic   conv;
    logic   shift;
    radix_t radix;
  } dig_ctrl_t;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0000, d};
    end
    return base + {4'b0000, d} - 8'd10;
  endfunction

endpackage

### sv/itoa_ifs.sv
// Valid/ready channel interfaces for the converter's input and result words.
// Depends on itoa_pkg.
interface itoa_in_if
  import itoa_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [ACTION_BITS-1:0] action;
  logic [VALUE_BITS-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface itoa_out_if
  import itoa_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink (input valid, char_code, last, output ready);
endinterface

### sv/itoa_digits.sv
// Digit shift register: bit-serial double dabble for decimal, direct load
// for octal and hex, then shifts one digit out per step. Depends on itoa_pkg.
module itoa_digits
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  dig_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic [3:0]             top_digit
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int NDIG = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
  localparam int EW = 4 * NDIG;
  localparam int OCT_SH = EW - 3 * OCT_DIGITS;
  localparam int HEX_SH = EW - 4 * HEX_DIGITS;

  logic [EW-1:0]          em_r, em_nxt;
  logic [VALUE_WIDTH-1:0] op_r, op_nxt;
  logic [EW-1:0]          ext;
  logic [EW-1:0]          adj;

  assign ext = {{(EW-VALUE_WIDTH){1'b0}}, mag};

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (em_r[4*i +: 4] >= 4'd5) ? em_r[4*i +: 4] + 4'd3 : em_r[4*i +: 4];
    end
  end

  always_comb begin
    em_nxt = em_r;
    op_nxt = op_r;
    if (ctrl.load) begin
      case (ctrl.radix)
        RADIX_OCT: em_nxt = ext << OCT_SH;
        RADIX_HEX: em_nxt = ext << HEX_SH;
        default: begin
          em_nxt = '0;
          op_nxt = mag;
        end
      endcase
    end else if (ctrl.conv) begin
      em_nxt = {adj[EW-2:0], op_r[VALUE_WIDTH-1]};
      op_nxt = op_r << 1;
    end else if (ctrl.shift) begin
      em_nxt = (ctrl.radix == RADIX_OCT) ? em_r << 3 : em_r << 4;
    end
  end

  always_ff @(posedge clk) begin
    em_r <= em_nxt;
    op_r <= op_nxt;
  end

  assign top_digit = (ctrl.radix == RADIX_OCT) ? {1'b0, em_r[EW-1 -: 3]} : em_r[EW-1 -: 4];

endmodule

### sv/integer_to_ascii_radix.sv
// Integer to ASCII converter, top level. Depends on itoa_pkg, itoa_ifs and
// itoa_digits.
//
// Takes one word (mode, operand) at a time and returns its text one
// character per result word, most significant first, last flagged; unused
// modes are dropped. in_word.ready is high only while idle. Each item is
// accepted and loaded into the digit register; decimal modes then run one
// step of bit-serial double dabble per operand bit through the BCD shift
// register. After that the digit register shifts one digit per cycle unless
// a character is held by a low out_word.ready: leading zeros are skipped,
// then each character is emitted (a '-' first for negative signed values).
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  itoa_in_if.sink     in_word,
  itoa_out_if.source  out_word
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int NDIG = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
  localparam int CW = $clog2(NDIG + 1);
  localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  state_t         state_r, state_nxt;
  radix_t         radix_r, radix_nxt;
  logic           upper_r, upper_nxt;
  logic           neg_r, neg_nxt;
  logic           started_r, started_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [BW-1:0]  bcnt_r, bcnt_nxt;

  logic [VALUE_WIDTH-1:0] val_w;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   sign_bit;
  dig_ctrl_t              ctrl;
  logic [3:0]             top_digit;
  logic                   show;

  assign val_w = in_word.value[VALUE_WIDTH-1:0];
  assign sign_bit = val_w[VALUE_WIDTH-1];

  itoa_digits #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digits (
    .clk(clk),
    .ctrl(ctrl),
    .mag(mag),
    .top_digit(top_digit)
  );

  assign show = started_r || (top_digit != 4'd0) || (cnt_r == CW'(1));

  always_comb begin
    state_nxt   = state_r;
    radix_nxt   = radix_r;
    upper_nxt   = upper_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    cnt_nxt     = cnt_r;
    bcnt_nxt    = bcnt_r;
    mag         = val_w;
    ctrl.load   = 1'b0;
    ctrl.conv   = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.radix  = radix_r;
    in_word.ready      = 1'b0;
    out_word.valid     = 1'b0;
    out_word.char_code = digit_char(top_digit, upper_r);
    out_word.last      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_word.ready = 1'b1;
        started_nxt = 1'b0;
        bcnt_nxt = BW'(VALUE_WIDTH - 1);
        neg_nxt = 1'b0;
        upper_nxt = 1'b0;
        if (in_word.valid) begin
          case (action_t'(in_word.action))
            ACT_SDEC: begin
              neg_nxt = sign_bit;
              if (sign_bit) begin
                mag = (~val_w) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
              end
              ctrl.load = 1'b1;
              ctrl.radix = RADIX_DEC;
              radix_nxt = RADIX_DEC;
              cnt_nxt = CW'(NDIG);
              state_nxt = ST_CONV;
            end
            ACT_UDEC: begin
              ctrl.load = 1'b1;
              ctrl.radix = RADIX_DEC;
              radix_nxt = RADIX_DEC;
              cnt_nxt = CW'(NDIG);
              state_nxt = ST_CONV;
            end
            ACT_OCT: begin
              ctrl.load = 1'b1;
              ctrl.radix = RADIX_OCT;
              radix_nxt = RADIX_OCT;
              cnt_nxt = CW'(OCT_DIGITS);
              state_nxt = ST_EMIT;
            end
            ACT_HEXL: begin
              ctrl.load = 1'b1;
              ctrl.radix = RADIX_HEX;
              radix_nxt = RADIX_HEX;
              cnt_nxt = CW'(HEX_DIGITS);
              state_nxt = ST_EMIT;
            end
            ACT_HEXU: begin
              ctrl.load = 1'b1;
              ctrl.radix = RADIX_HEX;
              radix_nxt = RADIX_HEX;
              upper_nxt = 1'b1;
              cnt_nxt = CW'(HEX_DIGITS);
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        if (bcnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end else begin
          bcnt_nxt = bcnt_r - BW'(1);
        end
      end
      ST_SIGN: begin
        out_word.valid = 1'b1;
        out_word.char_code = CHAR_MINUS;
        if (out_word.ready) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!show) begin
          ctrl.shift = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          out_word.valid = 1'b1;
          out_word.last = (cnt_r == CW'(1));
          if (out_word.ready) begin
            started_nxt = 1'b1;
            if (cnt_r == CW'(1)) begin
              state_nxt = ST_IDLE;
            end else begin
              ctrl.shift = 1'b1;
              cnt_nxt = cnt_r - CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      neg_r     <= 1'b0;
      cnt_r     <= '0;
      bcnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      neg_r     <= neg_nxt;
      cnt_r     <= cnt_nxt;
      bcnt_r    <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
    upper_r <= upper_nxt;
  end

endmodule
